// File: rtl/rrts_pkg.sv
`timescale 1ns / 1ps
package rrts_pkg;

    typedef enum logic [2:0] {
        ST_DEAD      = 3'd0,
        ST_READY     = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_SLEEPING  = 3'd3,
        ST_SUSPENDED = 3'd4,
        ST_BLOCKED   = 3'd5
    } task_state_t;

    // One row of the task table, apart from the sleep count.
    typedef struct packed {
        task_state_t st;
        logic        wait_valid;
        logic [2:0]  wait_sem;
    } entry_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [3:0]  task_id;
        logic [15:0] sleep_ticks;
        logic [2:0]  sem_id;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0] running_task;
        logic       tasking_on;
        logic       switched;
        logic [1:0] result_code;
    } result_item_t;

    localparam logic [3:0] CMD_TICK    = 4'd0;
    localparam logic [3:0] CMD_YIELD   = 4'd1;
    localparam logic [3:0] CMD_CREATE  = 4'd2;
    localparam logic [3:0] CMD_KILL    = 4'd3;
    localparam logic [3:0] CMD_SLEEP   = 4'd4;
    localparam logic [3:0] CMD_SUSPEND = 4'd5;
    localparam logic [3:0] CMD_RESUME  = 4'd6;
    localparam logic [3:0] CMD_ACQUIRE = 4'd7;
    localparam logic [3:0] CMD_RELEASE = 4'd8;
    localparam logic [3:0] CMD_START   = 4'd9;
    localparam logic [3:0] CMD_STOP    = 4'd10;

    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_BAD_ID   = 2'd1;
    localparam logic [1:0] RC_BLOCKED  = 2'd2;
    localparam logic [1:0] RC_INACTIVE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EDIT = 4'b0010,
        S_SEL  = 4'b0100,
        S_DONE = 4'b1000
    } fsm_t;

endpackage

// File: rtl/round_robin_task_scheduler.sv
`timescale 1ns / 1ps
// Round-robin task scheduler with sleep counts and binary semaphores.
// Commands arrive as items on in_item under in_valid / in_stall; each command
// gives exactly one result item on out_item under out_valid / out_stall,
// carrying the running task, the tasking flag, a switch flag and a code.
// The single configuration bit single_task_mode is written through cfg_we /
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce.
// The task table sits in a ring of TASK_COUNT cells that rotates by one entry
// per cycle past an edit point. Every command takes one full rotation; a
// command that runs a task selection takes two more rotations for the
// round-robin search, after which the result is registered on out_item.
// One item is worked on at a time; in_stall is high while a command is in work.
// A result waiting in the output register does not keep the next item out,
// but that item's result waits until the receiver takes the earlier one.
// Reset marks all tasks dead, clears the semaphores and turns tasking off.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int TASK_COUNT = 8,
    parameter int SEM_COUNT  = 8,
    parameter int SLEEP_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  cmd_item_t    in_item,
    output logic         out_valid,
    input  logic         out_stall,
    output result_item_t out_item
);

    localparam int IW = $clog2(TASK_COUNT);
    localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam logic [IW-1:0] LAST_ID = IW'(TASK_COUNT - 1);
    localparam logic [32:0]   SMAX = (33'd1 << SLEEP_BITS) - 33'd1;

    entry_t                ring_entry [TASK_COUNT];
    logic [SLEEP_BITS-1:0] ring_sleep [TASK_COUNT];
    entry_t                ed_entry;
    logic [SLEEP_BITS-1:0] ed_sleep;
    logic                  rot;

    fsm_t                  state_reg, state_next;
    logic [IW-1:0]         head_reg, head_next;
    logic                  pass_reg, pass_next;
    logic [3:0]            cmd_reg, cmd_next;
    logic [IW-1:0]         tid_reg, tid_next;
    logic [2:0]            sem_reg, sem_next;
    logic [SLEEP_BITS-1:0] ticks_reg, ticks_next;
    logic                  ok_reg, ok_next;
    logic                  swe_reg, swe_next;
    logic                  dec_reg, dec_next;
    logic                  sel_reg, sel_next;
    logic [IW-1:0]         from_reg, from_next;
    logic [1:0]            code_reg, code_next;
    logic                  claimed_reg, claimed_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic                  active_reg, active_next;
    logic [SEM_COUNT-1:0]  taken_reg, taken_next;
    logic                  stm_reg;
    logic                  out_valid_reg, out_valid_next;
    result_item_t          out_reg, out_next;

    logic                  id_ok, sem_ok, sem_busy;
    logic [IW-1:0]         tidx;
    logic [SW-1:0]         sidx;

    genvar gi;
    generate
        for (gi = 0; gi < TASK_COUNT; gi++)
        begin : g_cell
            if (gi == TASK_COUNT - 1)
            begin : g_tail
                rrts_cell #(.SLEEP_BITS(SLEEP_BITS)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (rot),
                    .nbr_entry (ed_entry),
                    .nbr_sleep (ed_sleep),
                    .entry     (ring_entry[gi]),
                    .sleep     (ring_sleep[gi])
                );
            end
            else
            begin : g_body
                rrts_cell #(.SLEEP_BITS(SLEEP_BITS)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (rot),
                    .nbr_entry (ring_entry[gi+1]),
                    .nbr_sleep (ring_sleep[gi+1]),
                    .entry     (ring_entry[gi]),
                    .sleep     (ring_sleep[gi])
                );
            end
        end
    endgenerate

    assign rot       = (state_reg == S_EDIT) || (state_reg == S_SEL);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign id_ok    = ({1'b0, in_item.task_id} < 5'(TASK_COUNT));
    assign sem_ok   = ({2'b0, in_item.sem_id} < 5'(SEM_COUNT));
    assign tidx     = IW'(in_item.task_id);
    assign sidx     = SW'(in_item.sem_id);
    assign sem_busy = sem_ok && taken_reg[sidx];

    // Edit point: the entry at the head of the ring is rewritten as it moves
    // to the tail, so one rotation visits every task in id order.
    always_comb
    begin
        entry_t                e;
        logic [SLEEP_BITS-1:0] s;
        logic                  hit_tid;
        logic                  hit_cur;
        logic                  consider;
        e            = ring_entry[0];
        s            = ring_sleep[0];
        hit_tid      = (head_reg == tid_reg);
        hit_cur      = (head_reg == cur_reg);
        consider     = 1'b0;
        found_next   = found_reg;
        claimed_next = claimed_reg;
        cur_next     = cur_reg;
        taken_next   = taken_reg;
        if (state_reg == S_EDIT)
        begin
            if (ok_reg)
            begin
                case (cmd_reg)
                    CMD_CREATE, CMD_KILL:
                    begin
                        if (hit_tid)
                        begin
                            e.st         = (cmd_reg == CMD_CREATE) ? ST_READY : ST_DEAD;
                            e.wait_valid = 1'b0;
                            s            = '0;
                        end
                    end
                    CMD_SLEEP:
                    begin
                        if (hit_cur)
                        begin
                            e.st = ST_SLEEPING;
                            s    = ticks_reg;
                        end
                    end
                    CMD_SUSPEND:
                    begin
                        if (hit_tid)
                            e.st = ST_SUSPENDED;
                    end
                    CMD_RESUME:
                    begin
                        if (hit_tid && e.st == ST_SUSPENDED)
                            e.st = ST_READY;
                    end
                    CMD_ACQUIRE:
                    begin
                        if (hit_cur)
                        begin
                            e.st         = ST_BLOCKED;
                            e.wait_valid = 1'b1;
                            e.wait_sem   = sem_reg;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (hit_cur)
                            e.wait_valid = 1'b0;
                        if (!found_reg && e.wait_valid && e.wait_sem == sem_reg
                            && e.st == ST_BLOCKED)
                        begin
                            e.st       = ST_READY;
                            found_next = 1'b1;
                        end
                    end
                    CMD_START:
                    begin
                        if (e.st == ST_RUNNING)
                            e.st = ST_READY;
                    end
                    CMD_STOP:
                    begin
                        if (hit_cur && e.st == ST_RUNNING)
                            e.st = ST_READY;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (swe_reg && hit_cur && e.st == ST_RUNNING)
                e.st = ST_READY;
            if (dec_reg && e.st == ST_SLEEPING)
            begin
                if (s <= SLEEP_BITS'(1))
                begin
                    s    = '0;
                    e.st = ST_READY;
                end
                else
                begin
                    s = s - SLEEP_BITS'(1);
                end
            end
        end
        else if (state_reg == S_SEL)
        begin
            // First rotation covers ids from the start point up, the second
            // the ids below it, which gives round-robin order.
            consider = !claimed_reg &&
                       ((!pass_reg && head_reg >= from_reg) ||
                        (pass_reg && head_reg < from_reg));
            if (consider && e.st == ST_READY)
            begin
                if (e.wait_valid && taken_reg[SW'(e.wait_sem)])
                begin
                    e.st = ST_BLOCKED;
                end
                else
                begin
                    if (e.wait_valid)
                    begin
                        taken_next[SW'(e.wait_sem)] = 1'b1;
                        e.wait_valid                = 1'b0;
                    end
                    e.st         = ST_RUNNING;
                    cur_next     = head_reg;
                    claimed_next = 1'b1;
                end
            end
        end
        ed_entry = e;
        ed_sleep = s;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        pass_next      = pass_reg;
        cmd_next       = cmd_reg;
        tid_next       = tid_reg;
        sem_next       = sem_reg;
        ticks_next     = ticks_reg;
        ok_next        = ok_reg;
        swe_next       = swe_reg;
        dec_next       = dec_reg;
        sel_next       = sel_reg;
        from_next      = from_reg;
        code_next      = code_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_item.cmd;
                    tid_next   = tidx;
                    sem_next   = in_item.sem_id;
                    ticks_next = ({17'b0, in_item.sleep_ticks} > SMAX) ?
                                 SMAX[SLEEP_BITS-1:0] : SLEEP_BITS'(in_item.sleep_ticks);
                    ok_next    = 1'b0;
                    swe_next   = 1'b0;
                    dec_next   = 1'b0;
                    sel_next   = 1'b0;
                    from_next  = (cur_reg == LAST_ID) ? '0 : cur_reg + IW'(1);
                    code_next  = RC_OK;
                    head_next  = '0;
                    state_next = S_EDIT;
                    case (in_item.cmd)
                        CMD_TICK, CMD_YIELD:
                        begin
                            if (!active_reg)
                                code_next = RC_INACTIVE;
                            else
                            begin
                                swe_next = !stm_reg;
                                sel_next = !stm_reg;
                                dec_next = !stm_reg && (in_item.cmd == CMD_TICK);
                            end
                        end
                        CMD_CREATE, CMD_RESUME:
                        begin
                            if (!id_ok)
                                code_next = RC_BAD_ID;
                            else
                                ok_next = 1'b1;
                        end
                        CMD_KILL, CMD_SUSPEND:
                        begin
                            if (!id_ok)
                                code_next = RC_BAD_ID;
                            else
                            begin
                                ok_next  = 1'b1;
                                swe_next = active_reg && !stm_reg;
                                sel_next = active_reg && !stm_reg;
                            end
                        end
                        CMD_SLEEP:
                        begin
                            if (!active_reg)
                                code_next = RC_INACTIVE;
                            else
                            begin
                                ok_next  = 1'b1;
                                swe_next = !stm_reg;
                                sel_next = !stm_reg;
                            end
                        end
                        CMD_ACQUIRE:
                        begin
                            if (!active_reg)
                                code_next = RC_INACTIVE;
                            else if (!sem_ok)
                                code_next = RC_BAD_ID;
                            else if (sem_busy)
                            begin
                                ok_next   = 1'b1;
                                code_next = RC_BLOCKED;
                                swe_next  = !stm_reg;
                                sel_next  = !stm_reg;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (!active_reg)
                                code_next = RC_INACTIVE;
                            else if (!sem_ok)
                                code_next = RC_BAD_ID;
                            else
                            begin
                                ok_next  = 1'b1;
                                swe_next = !stm_reg;
                                sel_next = !stm_reg;
                            end
                        end
                        CMD_START:
                        begin
                            if (!id_ok)
                                code_next = RC_BAD_ID;
                            else if (!active_reg)
                            begin
                                ok_next     = 1'b1;
                                sel_next    = 1'b1;
                                from_next   = tidx;
                                active_next = 1'b1;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (!active_reg)
                                code_next = RC_INACTIVE;
                            else
                            begin
                                ok_next     = 1'b1;
                                active_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EDIT:
            begin
                head_next = (head_reg == LAST_ID) ? '0 : head_reg + IW'(1);
                if (head_reg == LAST_ID)
                begin
                    pass_next  = 1'b0;
                    state_next = sel_reg ? S_SEL : S_DONE;
                end
            end
            S_SEL:
            begin
                head_next = (head_reg == LAST_ID) ? '0 : head_reg + IW'(1);
                if (head_reg == LAST_ID)
                begin
                    if (pass_reg)
                    begin
                        if (!claimed_next)
                            active_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                        pass_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.running_task = 3'(cur_reg);
                    out_next.tasking_on   = active_reg;
                    out_next.switched     = claimed_reg;
                    out_next.result_code  = code_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            pass_reg      <= 1'b0;
            claimed_reg   <= 1'b0;
            found_reg     <= 1'b0;
            cur_reg       <= '0;
            active_reg    <= 1'b0;
            taken_reg     <= '0;
            stm_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            swe_reg       <= 1'b0;
            dec_reg       <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            pass_reg      <= pass_next;
            cur_reg       <= cur_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            swe_reg       <= swe_next;
            dec_reg       <= dec_next;
            sel_reg       <= sel_next;
            if (cfg_we)
                stm_reg <= cfg_data;
            if (state_reg == S_IDLE && in_valid)
            begin
                claimed_reg <= 1'b0;
                found_reg   <= 1'b0;
                if (in_item.cmd == CMD_ACQUIRE && active_reg && sem_ok && !sem_busy)
                    taken_reg[sidx] <= 1'b1;
                else if (in_item.cmd == CMD_RELEASE && active_reg && sem_ok)
                    taken_reg[sidx] <= 1'b0;
            end
            else
            begin
                claimed_reg <= claimed_next;
                found_reg   <= found_next;
                taken_reg   <= taken_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        tid_reg   <= tid_next;
        sem_reg   <= sem_next;
        ticks_reg <= ticks_next;
        from_reg  <= from_next;
        code_reg  <= code_next;
        out_reg   <= out_next;
    end

endmodule

// File: rtl/rrts_cell.sv
`timescale 1ns / 1ps
module rrts_cell
    import rrts_pkg::*;
#(
    parameter int SLEEP_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift,
    input  entry_t                nbr_entry,
    input  logic [SLEEP_BITS-1:0] nbr_sleep,
    output entry_t                entry,
    output logic [SLEEP_BITS-1:0] sleep
);

    entry_t                entry_reg;
    logic [SLEEP_BITS-1:0] sleep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '{st: ST_DEAD, wait_valid: 1'b0, wait_sem: 3'd0};
            sleep_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= nbr_entry;
            sleep_reg <= nbr_sleep;
        end
    end

    assign entry = entry_reg;
    assign sleep = sleep_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import rrts_pkg::*;

    localparam int NTASK = 8;
    localparam int NSEM = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 40;
    localparam int CMD_BITS = $bits(cmd_item_t);

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_data;
    logic         in_valid;
    logic         in_stall;
    cmd_item_t    in_item;
    logic         out_valid;
    logic         out_stall;
    result_item_t out_item;

    round_robin_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Shadow copy of the scheduler state.
    task_state_t  sh_state [NTASK];
    logic [15:0]  sh_sleep [NTASK];
    logic         sh_wait [NTASK];
    logic [2:0]   sh_wsem [NTASK];
    logic         sh_sem [NSEM];
    logic [2:0]   sh_cur;
    logic         sh_active;
    logic         sh_single;

    result_item_t pending_results[$];
    logic         pending_known[$];
    int           fail_count;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void clear_shadow();
        for (int i = 0; i < NTASK; i++)
        begin
            sh_state[i] = ST_DEAD;
            sh_sleep[i] = '0;
            sh_wait[i] = 1'b0;
            sh_wsem[i] = '0;
        end
        for (int i = 0; i < NSEM; i++)
            sh_sem[i] = 1'b0;
        sh_cur = '0;
        sh_active = 1'b0;
        sh_single = 1'b0;
    endfunction

    // Round-robin pick from position first, retrying any pending acquire.
    function automatic logic pick_task(int first);
        int from;
        int t;
        from = first;
        for (int n = 0; n <= NTASK; n++)
        begin
            t = -1;
            for (int k = 0; k < NTASK; k++)
            begin
                if (t < 0 && sh_state[(from + k) % NTASK] == ST_READY)
                    t = (from + k) % NTASK;
            end
            if (t < 0)
            begin
                sh_active = 1'b0;
                return 1'b0;
            end
            if (sh_wait[t])
            begin
                if (sh_sem[sh_wsem[t]])
                begin
                    sh_state[t] = ST_BLOCKED;
                    from = (t + 1) % NTASK;
                    continue;
                end
                sh_sem[sh_wsem[t]] = 1'b1;
                sh_wait[t] = 1'b0;
            end
            sh_cur = t[2:0];
            sh_state[t] = ST_RUNNING;
            return 1'b1;
        end
        sh_active = 1'b0;
        return 1'b0;
    endfunction

    function automatic logic switch_task(logic is_tick);
        int c;
        c = sh_cur;
        if (sh_single)
            return 1'b0;
        if (sh_state[c] == ST_RUNNING)
            sh_state[c] = ST_READY;
        if (is_tick)
        begin
            for (int i = 0; i < NTASK; i++)
            begin
                if (sh_state[i] == ST_SLEEPING)
                begin
                    if (sh_sleep[i] <= 1)
                    begin
                        sh_sleep[i] = '0;
                        sh_state[i] = ST_READY;
                    end
                    else
                        sh_sleep[i] = sh_sleep[i] - 1'b1;
                end
            end
        end
        return pick_task((c + 1) % NTASK);
    endfunction

    function automatic result_item_t schedule_command(cmd_item_t c);
        result_item_t r;
        logic sw;
        logic [1:0] rc;
        int id;
        int cur;
        logic id_ok;
        sw = 1'b0;
        rc = RC_OK;
        id = c.task_id;
        cur = sh_cur;
        id_ok = c.task_id < NTASK;
        case (c.cmd)
            CMD_TICK, CMD_YIELD:
                if (!sh_active) rc = RC_INACTIVE;
                else sw = switch_task(c.cmd == CMD_TICK);
            CMD_CREATE:
                if (!id_ok) rc = RC_BAD_ID;
                else
                begin
                    sh_state[id] = ST_READY;
                    sh_sleep[id] = '0;
                    sh_wait[id] = 1'b0;
                end
            CMD_KILL:
                if (!id_ok) rc = RC_BAD_ID;
                else
                begin
                    sh_state[id] = ST_DEAD;
                    sh_sleep[id] = '0;
                    sh_wait[id] = 1'b0;
                    if (sh_active) sw = switch_task(1'b0);
                end
            CMD_SLEEP:
                if (!sh_active) rc = RC_INACTIVE;
                else
                begin
                    sh_state[cur] = ST_SLEEPING;
                    sh_sleep[cur] = c.sleep_ticks;
                    sw = switch_task(1'b0);
                end
            CMD_SUSPEND:
                if (!id_ok) rc = RC_BAD_ID;
                else
                begin
                    sh_state[id] = ST_SUSPENDED;
                    if (sh_active) sw = switch_task(1'b0);
                end
            CMD_RESUME:
                if (!id_ok) rc = RC_BAD_ID;
                else if (sh_state[id] == ST_SUSPENDED) sh_state[id] = ST_READY;
            CMD_ACQUIRE:
                if (!sh_active) rc = RC_INACTIVE;
                else if (!sh_sem[c.sem_id]) sh_sem[c.sem_id] = 1'b1;
                else
                begin
                    sh_state[cur] = ST_BLOCKED;
                    sh_wait[cur] = 1'b1;
                    sh_wsem[cur] = c.sem_id;
                    rc = RC_BLOCKED;
                    sw = switch_task(1'b0);
                end
            CMD_RELEASE:
                if (!sh_active) rc = RC_INACTIVE;
                else
                begin
                    sh_wait[cur] = 1'b0;
                    sh_sem[c.sem_id] = 1'b0;
                    // Only the lowest-numbered waiter wakes.
                    for (int i = 0; i < NTASK; i++)
                    begin
                        if (sh_wait[i] && sh_wsem[i] == c.sem_id
                            && sh_state[i] == ST_BLOCKED)
                        begin
                            sh_state[i] = ST_READY;
                            break;
                        end
                    end
                    sw = switch_task(1'b0);
                end
            CMD_START:
                if (!id_ok) rc = RC_BAD_ID;
                else if (!sh_active)
                begin
                    for (int i = 0; i < NTASK; i++)
                        if (sh_state[i] == ST_RUNNING) sh_state[i] = ST_READY;
                    sh_active = 1'b1;
                    sw = pick_task(id);
                end
            CMD_STOP:
                if (!sh_active) rc = RC_INACTIVE;
                else
                begin
                    sh_active = 1'b0;
                    if (sh_state[cur] == ST_RUNNING) sh_state[cur] = ST_READY;
                end
            default: ;
        endcase
        r.running_task = sh_cur;
        r.tasking_on = sh_active;
        r.switched = sw;
        r.result_code = rc;
        return r;
    endfunction

    // Receiver: stall at random and compare each result item.
    always @(posedge clk)
    begin
        result_item_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with no expectation: %h", out_item);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    void'(pending_known.pop_front());
                    if (out_item.running_task !== exp_r.running_task)
                    begin
                        $error("running_task exp %0d got %0d",
                               exp_r.running_task, out_item.running_task);
                        fail_count++;
                    end
                    if (out_item.tasking_on !== exp_r.tasking_on)
                    begin
                        $error("tasking_on exp %0d got %0d",
                               exp_r.tasking_on, out_item.tasking_on);
                        fail_count++;
                    end
                    if (out_item.switched !== exp_r.switched)
                    begin
                        $error("switched exp %0d got %0d",
                               exp_r.switched, out_item.switched);
                        fail_count++;
                    end
                    if (out_item.result_code !== exp_r.result_code)
                    begin
                        $error("result_code exp %0d got %0d",
                               exp_r.result_code, out_item.result_code);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // The item stays on the port after it is taken; the next call replaces it
    // or drops valid in the same time step.
    task automatic send_item(cmd_item_t c, logic has_fixed, result_item_t fixed);
        result_item_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = schedule_command(c);
        if (has_fixed && r !== fixed)
        begin
            $error("directed row %h: prediction %h vs typed %h", c, r, fixed);
            fail_count++;
        end
        pending_results.push_back(r);
        pending_known.push_back(has_fixed);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_single = m;
    endtask

    function automatic cmd_item_t mk(logic [3:0] op, logic [3:0] tid,
                                     logic [15:0] tk, logic [2:0] sid);
        cmd_item_t c;
        c.cmd = op;
        c.task_id = tid;
        c.sleep_ticks = tk;
        c.sem_id = sid;
        return c;
    endfunction

    // Mostly well-formed traffic: valid ids, frequent ticks, some noise.
    function automatic cmd_item_t random_command();
        cmd_item_t c;
        int pick;
        c = cmd_item_t'(CMD_BITS'($urandom));
        pick = $urandom_range(99);
        if (pick < 90)
        begin
            c.task_id = 4'($urandom_range(NTASK - 1));
            c.sleep_ticks = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
            case ($urandom_range(11))
                0, 1, 2: c.cmd = CMD_TICK;
                3: c.cmd = CMD_YIELD;
                4: c.cmd = CMD_CREATE;
                5: c.cmd = CMD_KILL;
                6: c.cmd = CMD_SLEEP;
                7: c.cmd = ($urandom_range(1)) ? CMD_SUSPEND : CMD_RESUME;
                8: c.cmd = CMD_ACQUIRE;
                9: c.cmd = CMD_RELEASE;
                10: c.cmd = CMD_START;
                default: c.cmd = ($urandom_range(3) == 0) ? CMD_STOP : CMD_CREATE;
            endcase
        end
        return c;
    endfunction

    typedef struct {
        cmd_item_t    c;
        logic         fixed;
        result_item_t r;
    } row_t;

    row_t rows[$];

    initial
    begin
        result_item_t none;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 20;
        recv_idle_pct = 73;
        clear_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; typed results where obvious from the rules.
        rows.push_back('{mk(CMD_TICK, 0, 0, 0), 1, '{3'd0, 1'b0, 1'b0, RC_INACTIVE}});
        rows.push_back('{mk(CMD_STOP, 0, 0, 0), 1, '{3'd0, 1'b0, 1'b0, RC_INACTIVE}});
        rows.push_back('{mk(CMD_START, 4'd15, 0, 0), 1, '{3'd0, 1'b0, 1'b0, RC_BAD_ID}});
        rows.push_back('{mk(CMD_START, 3, 0, 0), 1, '{3'd0, 1'b0, 1'b0, RC_OK}});
        rows.push_back('{mk(CMD_CREATE, 4'd8, 0, 0), 1, '{3'd0, 1'b0, 1'b0, RC_BAD_ID}});
        rows.push_back('{mk(CMD_CREATE, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_CREATE, 7, 0, 0), 0, none});
        rows.push_back('{mk(CMD_CREATE, 3, 0, 0), 0, none});
        rows.push_back('{mk(CMD_START, 7, 0, 0), 1, '{3'd7, 1'b1, 1'b1, RC_OK}});
        rows.push_back('{mk(CMD_START, 0, 0, 0), 1, '{3'd7, 1'b1, 1'b0, RC_OK}});
        rows.push_back('{mk(CMD_ACQUIRE, 0, 0, 7), 0, none});
        rows.push_back('{mk(CMD_SLEEP, 0, 16'hFFFF, 0), 0, none});
        rows.push_back('{mk(CMD_ACQUIRE, 0, 0, 7), 0, none});
        rows.push_back('{mk(CMD_SLEEP, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_RELEASE, 0, 0, 7), 0, none});
        rows.push_back('{mk(CMD_SUSPEND, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_RESUME, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_KILL, 4'd9, 0, 0), 1, '{3'd0, 1'b0, 1'b0, RC_BAD_ID}});
        rows.push_back('{mk(CMD_KILL, 3, 0, 0), 0, none});
        rows.push_back('{mk(CMD_YIELD, 0, 0, 0), 0, none});
        rows.push_back('{mk(4'd15, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_STOP, 0, 0, 0), 0, none});
        foreach (rows[i])
        begin
            // The typed bad-id row late in the table depends on earlier state.
            if (rows[i].fixed && rows[i].c.cmd == CMD_KILL)
                rows[i].r = '{sh_cur, sh_active, 1'b0, RC_BAD_ID};
            send_item(rows[i].c, rows[i].fixed, rows[i].r);
        end

        // Sender waits out every result at least once here.
        drain_results();
        write_mode(1'b1);
        for (int i = 0; i < 120; i++)
            send_item(random_command(), 1'b0, none);
        write_mode(1'b0);
        for (int i = 0; i < 330; i++)
            send_item(random_command(), 1'b0, none);

        send_idle_pct = 73;
        recv_idle_pct = 20;
        for (int i = 0; i < 330; i++)
            send_item(random_command(), 1'b0, none);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(1'b1);
        for (int i = 0; i < 40; i++)
            send_item(random_command(), 1'b0, none);
        write_mode(1'b0);
        for (int i = 0; i < 200; i++)
            send_item(random_command(), 1'b0, none);

        drain_results();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
